/* sv/ffra_pkg.sv */
// shared types and constants for the first-fit run allocator
package ffra_pkg;

   localparam int UNIT_BITS      = 256;
   localparam int WORD_BITS      = 16;
   localparam int WORDS_PER_SECT = UNIT_BITS / WORD_BITS;
   localparam int BIT_IDX_W      = 4;
   localparam int LEN_W          = 9;
   localparam int SECTOR_W       = 32;
   localparam int UNIT_ADDR_W    = 40;
   localparam int BYTE_SHIFT     = 10;
   localparam int ADDR_W         = 50;
   localparam int ADDR_OFFSET    = 2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_FINISH
   } state_type;

   typedef logic [WORD_BITS-1:0] map_word_type;

endpackage

/* sv/ffra_ram.sv */
// generic simple dual-port ram with registered read
module ffra_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* sv/first_fit_run_allocator_core.sv */
// first-fit contiguous run allocator over a used-flag bitmap
//
// The used map lives in one RAM of 16-flag words, MAP_SECTORS*16 words deep.
// After reset, and on every clear request, a clearing pass writes one word per
// cycle with busy high; a clear request answers with found=0 at its end. An
// allocate request reads one map word per cycle, up to MAP_SECTORS*16 words;
// a hit then rewrites the covered words by read-modify-write, with a read
// state and a write state per word, and a finish state forms the address.
// Lengths of 0 or above 256 answer the cycle after start. Each answer appears
// on rsp_* for one cycle with rsp_strobe high and cannot be held off; busy may
// already be low in that cycle so the next word can be started at once.
module first_fit_run_allocator_core #(
   parameter int MAP_SECTORS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [8:0]  req_run_length,
   output logic        rsp_strobe,
   output logic        rsp_found,
   output logic [49:0] rsp_address,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int WORDS = MAP_SECTORS * ffra_pkg::WORDS_PER_SECT;
   localparam int AW    = $clog2(WORDS);
   localparam int LW    = AW + ffra_pkg::BIT_IDX_W;
   localparam int WB    = ffra_pkg::WORD_BITS;
   localparam int LENW  = ffra_pkg::LEN_W;
   localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

   ffra_pkg::state_type state_ff, state_in;

   logic [AW-1:0]   clr_ptr_ff, clr_ptr_in;
   logic            clr_rsp_ff, clr_rsp_in;
   logic [AW-1:0]   issue_ptr_ff, issue_ptr_in;
   logic            issue_done_ff, issue_done_in;
   logic [AW-1:0]   chk_ptr_ff, chk_ptr_in;
   logic            chk_vld_ff, chk_vld_in;
   logic [LENW-1:0] count_ff, count_in;
   logic [LENW-1:0] len_ff, len_in;
   logic [LW-1:0]   end_unit_ff, end_unit_in;
   logic [LW-1:0]   lo_unit_ff, lo_unit_in;
   logic [AW-1:0]   mark_ptr_ff, mark_ptr_in;
   logic [ffra_pkg::SECTOR_W-1:0] first_sector_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_found_ff, rsp_found_in;
   logic [49:0]     rsp_address_ff, rsp_address_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   ffra_pkg::map_word_type wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   ffra_pkg::map_word_type rd_data;

   // per-word run search
   logic [LENW-1:0]        count_base;
   logic [LENW-1:0]        run_len [WB];
   logic [WB-1:0]          hit;
   logic                   any_hit;
   logic [3:0]             hit_idx;
   logic [LW-1:0]          hit_unit;
   logic [LW-1:0]          hit_lo;
   ffra_pkg::map_word_type mark_mask;
   logic [ffra_pkg::UNIT_ADDR_W-1:0] unit_addr;
   logic                   bad_len;

   ffra_ram #(
      .WIDTH (WB),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic       any_used;
      logic [3:0] last_used;
      count_base = (chk_ptr_ff[3:0] == 4'd0) ? '0 : count_ff;
      for (int j = 0; j < WB; j++) begin
         any_used  = 1'b0;
         last_used = '0;
         for (int i = 0; i <= j; i++) begin
            if (rd_data[i]) begin
               any_used  = 1'b1;
               last_used = 4'(i);
            end
         end
         if (any_used) begin
            run_len[j] = LENW'(4'(j) - last_used);
         end else begin
            run_len[j] = count_base + LENW'(j + 1);
         end
         hit[j] = (run_len[j] >= len_ff);
      end
      any_hit = |hit;
      hit_idx = '0;
      for (int j = WB - 1; j >= 0; j--) begin
         if (hit[j]) begin
            hit_idx = 4'(j);
         end
      end
   end

   assign hit_unit = {chk_ptr_ff, hit_idx};
   assign hit_lo   = hit_unit + LW'(1) - LW'(len_ff);

   always_comb begin
      logic [LW-1:0] u;
      for (int b = 0; b < WB; b++) begin
         u            = {mark_ptr_ff, 4'(b)};
         mark_mask[b] = (u >= lo_unit_ff) && (u <= end_unit_ff);
      end
   end

   assign unit_addr = {first_sector_ff, 8'd0}
                    + ffra_pkg::UNIT_ADDR_W'(end_unit_ff)
                    + ffra_pkg::UNIT_ADDR_W'(ffra_pkg::ADDR_OFFSET)
                    - ffra_pkg::UNIT_ADDR_W'(len_ff);

   assign bad_len = (req_run_length == '0) ||
                    (req_run_length[8] && (req_run_length[7:0] != '0));

   always_comb begin
      state_in       = state_ff;
      clr_ptr_in     = clr_ptr_ff;
      clr_rsp_in     = clr_rsp_ff;
      issue_ptr_in   = issue_ptr_ff;
      issue_done_in  = issue_done_ff;
      chk_ptr_in     = chk_ptr_ff;
      chk_vld_in     = 1'b0;
      count_in       = count_ff;
      len_in         = len_ff;
      end_unit_in    = end_unit_ff;
      lo_unit_in     = lo_unit_ff;
      mark_ptr_in    = mark_ptr_ff;
      rsp_valid_in   = 1'b0;
      rsp_found_in   = 1'b0;
      rsp_address_in = '0;
      wr_en          = 1'b0;
      wr_addr        = clr_ptr_ff;
      wr_data        = '0;
      rd_en          = 1'b0;
      rd_addr        = issue_ptr_ff;
      case (state_ff)
         ffra_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            if (clr_ptr_ff == LAST_WORD) begin
               clr_ptr_in   = '0;
               clr_rsp_in   = 1'b0;
               rsp_valid_in = clr_rsp_ff;
               state_in     = ffra_pkg::ST_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + AW'(1);
            end
         end
         ffra_pkg::ST_IDLE: begin
            if (start) begin
               if (req_kind == ffra_pkg::KIND_CLEAR) begin
                  clr_rsp_in = 1'b1;
                  state_in   = ffra_pkg::ST_CLEAR;
               end else if (bad_len) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  len_in        = req_run_length;
                  issue_ptr_in  = '0;
                  issue_done_in = 1'b0;
                  count_in      = '0;
                  state_in      = ffra_pkg::ST_SCAN;
               end
            end
         end
         ffra_pkg::ST_SCAN: begin
            rd_en      = !issue_done_ff;
            chk_vld_in = !issue_done_ff;
            chk_ptr_in = issue_ptr_ff;
            if (!issue_done_ff) begin
               if (issue_ptr_ff == LAST_WORD) begin
                  issue_done_in = 1'b1;
               end else begin
                  issue_ptr_in = issue_ptr_ff + AW'(1);
               end
            end
            if (chk_vld_ff) begin
               count_in = run_len[WB-1];
               if (any_hit) begin
                  chk_vld_in  = 1'b0;
                  end_unit_in = hit_unit;
                  lo_unit_in  = hit_lo;
                  mark_ptr_in = hit_lo[LW-1:4];
                  state_in    = ffra_pkg::ST_MARK_RD;
               end else if (chk_ptr_ff == LAST_WORD) begin
                  chk_vld_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = ffra_pkg::ST_IDLE;
               end
            end
         end
         ffra_pkg::ST_MARK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = mark_ptr_ff;
            state_in = ffra_pkg::ST_MARK_WR;
         end
         ffra_pkg::ST_MARK_WR: begin
            wr_en   = 1'b1;
            wr_addr = mark_ptr_ff;
            wr_data = rd_data | mark_mask;
            if (mark_ptr_ff == end_unit_ff[LW-1:4]) begin
               state_in = ffra_pkg::ST_FINISH;
            end else begin
               mark_ptr_in = mark_ptr_ff + AW'(1);
               state_in    = ffra_pkg::ST_MARK_RD;
            end
         end
         ffra_pkg::ST_FINISH: begin
            rsp_valid_in   = 1'b1;
            rsp_found_in   = 1'b1;
            rsp_address_in = {unit_addr, ffra_pkg::BYTE_SHIFT'(0)};
            state_in       = ffra_pkg::ST_IDLE;
         end
         default: begin
            state_in = ffra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ffra_pkg::ST_CLEAR;
         clr_ptr_ff      <= '0;
         clr_rsp_ff      <= 1'b0;
         issue_done_ff   <= 1'b0;
         chk_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         first_sector_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ptr_ff    <= clr_ptr_in;
         clr_rsp_ff    <= clr_rsp_in;
         issue_done_ff <= issue_done_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            first_sector_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ptr_ff   <= issue_ptr_in;
      chk_ptr_ff     <= chk_ptr_in;
      count_ff       <= count_in;
      len_ff         <= len_in;
      end_unit_ff    <= end_unit_in;
      lo_unit_ff     <= lo_unit_in;
      mark_ptr_ff    <= mark_ptr_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_address_ff <= rsp_address_in;
   end

   assign busy        = (state_ff != ffra_pkg::ST_IDLE);
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_address = rsp_address_ff;

endmodule

/* sv/ffra_checker.sv */
// port-level checks for the first-fit run allocator, bound to the top level
module ffra_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_found,
   input logic [49:0] rsp_address
);

   // a failed or cleared word carries a zero address
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_address == '0)
      else $error("nonzero address without found");

   // allocated addresses fall on 1 KiB units
   a_unit_align : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found |-> rsp_address[9:0] == '0)
      else $error("allocated address not unit aligned");

   // an accepted word either starts work or answers at once
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted word dropped");

   // no word without a request or work in flight
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || start))
      else $error("word with nothing in flight");

   // map clearing pass follows reset
   a_reset_clear : assert property (@(posedge clock)
      reset |=> busy && !rsp_strobe)
      else $error("no clearing pass after reset");

endmodule

bind first_fit_run_allocator_core ffra_checker u_ffra_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_found   (rsp_found),
   .rsp_address (rsp_address)
);

/* dv/first_fit_run_allocator_core_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the first-fit run allocator core
module first_fit_run_allocator_core_tb;

   localparam int MAP_SECTORS = 16;
   localparam int MAP_UNITS   = MAP_SECTORS * ffra_pkg::UNIT_BITS;

   typedef struct packed {
      logic                        found;
      logic [ffra_pkg::ADDR_W-1:0] address;
   } alloc_result_type;

   class alloc_scoreboard_type;
      bit                              used_map [MAP_UNITS];
      logic [ffra_pkg::SECTOR_W-1:0]   base_sector;
      alloc_result_type                expected_q [$];
      int                              errors;
      int                              hits;
      int                              misses;
      int                              clears;
      int                              checked;

      function void set_base(logic [ffra_pkg::SECTOR_W-1:0] value);
         base_sector = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_word(logic kind, logic [ffra_pkg::LEN_W-1:0] len);
         alloc_result_type res;
         int               s;
         int               j;
         int               k;
         int               run;
         int               first;
         int               ub;
         logic [63:0]      unit;
         bit               done;
         res  = '0;
         done = 0;
         ub   = ffra_pkg::UNIT_BITS;
         if (kind == ffra_pkg::KIND_CLEAR) begin
            foreach (used_map[i]) used_map[i] = 0;
            clears++;
         end else begin
            if (len != 0 && len <= ub) begin
               for (s = 0; s < MAP_SECTORS && !done; s++) begin
                  run   = 0;
                  first = 0;
                  for (j = 0; j < ub && !done; j++) begin
                     if (!used_map[s*ub + j]) begin
                        if (run == 0) first = j;
                        run++;
                     end else begin
                        run = 0;
                     end
                     if (run == len) begin
                        for (k = first; k <= j; k++) used_map[s*ub + k] = 1;
                        unit = (64'(base_sector) + 64'(s)) * 64'(ub) + 64'(j)
                               + 64'(ffra_pkg::ADDR_OFFSET) - 64'(len);
                        res.found   = 1'b1;
                        res.address = ffra_pkg::ADDR_W'(unit << ffra_pkg::BYTE_SHIFT);
                        done        = 1;
                     end
                  end
               end
            end
            if (done) hits++;
            else misses++;
         end
         expected_q.push_back(res);
      endfunction

      function void check_result(logic found, logic [ffra_pkg::ADDR_W-1:0] address);
         alloc_result_type exp_res;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result found=%0b address=%h",
                     $time, found, address);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         checked++;
         if (found !== exp_res.found) begin
            $display("%0t: found mismatch expected=%0b actual=%0b",
                     $time, exp_res.found, found);
            errors++;
         end
         if (address !== exp_res.address) begin
            $display("%0t: address mismatch expected=%h actual=%h",
                     $time, exp_res.address, address);
            errors++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_kind;
   logic [ffra_pkg::LEN_W-1:0]  req_run_length;
   logic                        rsp_strobe;
   logic                        rsp_found;
   logic [ffra_pkg::ADDR_W-1:0] rsp_address;
   logic                        csr_wr_en;
   logic [31:0]                 csr_wr_data;

   alloc_scoreboard_type        sb;
   int                          settings;

   first_fit_run_allocator_core #(
      .MAP_SECTORS (MAP_SECTORS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_run_length (req_run_length),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_address    (rsp_address),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_found, rsp_address);
         if (start && !busy) sb.note_word(req_kind, req_run_length);
      end
   end

   task automatic send_word(logic kind, logic [ffra_pkg::LEN_W-1:0] len);
      start          = 1'b1;
      req_kind       = kind;
      req_run_length = len;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle_burst(int cycles);
      start          = 1'b0;
      req_kind       = 1'($urandom);
      req_run_length = ffra_pkg::LEN_W'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_first_sector(logic [31:0] value);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.set_base(value);
      settings++;
   endtask

   task automatic directed_words();
      send_word(ffra_pkg::KIND_CLEAR, 9'd0);
      send_word(ffra_pkg::KIND_ALLOC, 9'd0);
      send_word(ffra_pkg::KIND_ALLOC, 9'd257);
      send_word(ffra_pkg::KIND_ALLOC, 9'd511);
      send_word(ffra_pkg::KIND_ALLOC, 9'd1);
      // sector 0 now too short for a full run, so it lands in sector 1
      send_word(ffra_pkg::KIND_ALLOC, 9'd256);
      send_word(ffra_pkg::KIND_ALLOC, 9'd255);
      repeat (MAP_SECTORS - 2) send_word(ffra_pkg::KIND_ALLOC, 9'd256);
      send_word(ffra_pkg::KIND_ALLOC, 9'd1);
      send_word(ffra_pkg::KIND_CLEAR, 9'd511);
      // free tail of sector 0 plus head of sector 1 must not be joined
      send_word(ffra_pkg::KIND_ALLOC, 9'd200);
      send_word(ffra_pkg::KIND_ALLOC, 9'd100);
   endtask

   task automatic random_words(int count, int idle_pct);
      int                         pick;
      logic                       kind;
      logic [ffra_pkg::LEN_W-1:0] len;
      for (int i = 0; i < count; i++) begin
         if (idle_pct > 0 && (i % 64) < 40 && $urandom_range(0, 99) < idle_pct)
            idle_burst($urandom_range(1, 3));
         pick = $urandom_range(0, 99);
         kind = ffra_pkg::KIND_ALLOC;
         if (pick < 4) begin
            kind = ffra_pkg::KIND_CLEAR;
            len  = ffra_pkg::LEN_W'($urandom);
         end else if (pick < 8) begin
            len = 9'd0;
         end else if (pick < 12) begin
            len = ffra_pkg::LEN_W'($urandom_range(257, 511));
         end else if (pick < 18) begin
            len = 9'd256;
         end else if (pick < 60) begin
            len = ffra_pkg::LEN_W'($urandom_range(1, 16));
         end else begin
            len = ffra_pkg::LEN_W'($urandom_range(17, 255));
         end
         send_word(kind, len);
      end
   endtask

   initial begin
      int waited;
      sb             = new();
      settings       = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = ffra_pkg::KIND_ALLOC;
      req_run_length = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      while (busy) @(negedge clock);

      write_first_sector(32'h0000_0000);
      directed_words();
      random_words(180, 30);
      drain();
      write_first_sector(32'hFFFF_FFFF);
      send_word(ffra_pkg::KIND_CLEAR, 9'd0);
      random_words(200, 20);
      drain();
      write_first_sector($urandom);
      random_words(200, 40);
      drain();
      write_first_sector(32'h8000_0000);
      random_words(200, 15);
      drain();
      write_first_sector(32'h0000_7FFF);
      random_words(200, 0);

      start  = 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (40) @(negedge clock);

      $display("covered %0d results: %0d runs placed, %0d refused, %0d map clears",
               sb.checked, sb.hits, sb.misses, sb.clears);
      $display("over %0d base sector settings including both extremes", settings);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("%0t: timeout", $time);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
